// ----- rtl/vpc_pkg.sv -----
// Shared types and constants for the voxel polynomial calibration pipeline.
package vpc_pkg;

	localparam int VOX_W = 16;
	localparam int COEF_W = 32;
	localparam int ACC_W = 64;
	localparam int PROD_W = ACC_W + VOX_W;
	localparam int OUT_W = 32;
	localparam int DEG_W = 3;
	localparam int NUM_COEFS = 7;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam int DEF_MAX_DEGREE = 6;
	localparam int DEF_COEF_FRAC_BITS = 24;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_DEGREE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_BASE = 3'd1;

	localparam logic [DEG_W-1:0] DEGREE_RESET = 3'd1;
	localparam logic signed [COEF_W-1:0] COEF_P1_RESET = 32'sd16777216;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
	localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	// Payload that travels down the Horner chain.
	typedef struct packed {
		logic signed [VOX_W-1:0] x;
		logic signed [ACC_W-1:0] acc;
		logic                    sat;
	} vpc_item_t;

endpackage

// ----- rtl/vpc_horner_step.sv -----
// One Horner step: a registered multiply by the voxel, then a registered saturating add.
module vpc_horner_step (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   active,
	input  logic signed [vpc_pkg::COEF_W-1:0]      coef,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  vpc_pkg::vpc_item_t                     in_item,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output vpc_pkg::vpc_item_t                     out_item
);

	logic                                   v_s1;
	logic signed [vpc_pkg::VOX_W-1:0]       x_s1;
	logic signed [vpc_pkg::PROD_W-1:0]      prod_s1;
	logic                                   sat_s1;
	logic                                   v_s2;
	vpc_pkg::vpc_item_t                     item_s2;

	logic                                   en_s1;
	logic                                   en_s2;
	logic signed [vpc_pkg::PROD_W-1:0]      prod_d;
	logic                                   prod_ovf;
	logic signed [vpc_pkg::ACC_W-1:0]       prod_sat;
	logic signed [vpc_pkg::ACC_W:0]         sum;
	logic                                   sum_ovf;
	logic signed [vpc_pkg::ACC_W-1:0]       acc_d;

	assign en_s2    = !v_s2 || out_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	// A step above the configured degree passes the accumulator through unchanged.
	always_comb begin
		if (active) begin
			prod_d = in_item.acc * in_item.x;
		end else begin
			prod_d = vpc_pkg::PROD_W'(in_item.acc);
		end
	end

	always_comb begin
		prod_ovf = !((&prod_s1[vpc_pkg::PROD_W-1:vpc_pkg::ACC_W-1]) ||
			!(|prod_s1[vpc_pkg::PROD_W-1:vpc_pkg::ACC_W-1]));
		if (prod_ovf) begin
			prod_sat = prod_s1[vpc_pkg::PROD_W-1] ? vpc_pkg::ACC_MIN : vpc_pkg::ACC_MAX;
		end else begin
			prod_sat = prod_s1[vpc_pkg::ACC_W-1:0];
		end
		sum = {prod_sat[vpc_pkg::ACC_W-1], prod_sat};
		if (active) begin
			sum = sum + {{(vpc_pkg::ACC_W+1-vpc_pkg::COEF_W){coef[vpc_pkg::COEF_W-1]}}, coef};
		end
		sum_ovf = sum[vpc_pkg::ACC_W] != sum[vpc_pkg::ACC_W-1];
		if (sum_ovf) begin
			acc_d = sum[vpc_pkg::ACC_W] ? vpc_pkg::ACC_MIN : vpc_pkg::ACC_MAX;
		end else begin
			acc_d = sum[vpc_pkg::ACC_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= in_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			x_s1    <= in_item.x;
			prod_s1 <= prod_d;
			sat_s1  <= in_item.sat;
		end
		if (en_s2 && v_s1) begin
			item_s2.x   <= x_s1;
			item_s2.acc <= acc_d;
			item_s2.sat <= sat_s1 || prod_ovf || sum_ovf;
		end
	end

	assign out_valid = v_s2;
	assign out_item  = item_s2;

endmodule

// ----- rtl/vpc_round_sat.sv -----
// Output stage: truncation toward zero to an integer, 32-bit clamp and the output register.
module vpc_round_sat #(
	parameter int COEF_FRAC_BITS = vpc_pkg::DEF_COEF_FRAC_BITS
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  vpc_pkg::vpc_item_t                     in_item,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [vpc_pkg::OUT_W-1:0]       out_value,
	output logic                                   out_sat
);

	localparam int SUM_W = vpc_pkg::ACC_W + 1;

	logic                                   valid_q;
	logic signed [vpc_pkg::OUT_W-1:0]       value_q;
	logic                                   sat_q;
	logic                                   en;
	logic signed [SUM_W-1:0]                bias;
	logic signed [SUM_W-1:0]                biased;
	logic signed [SUM_W-1:0]                quot;
	logic                                   ovf;
	logic signed [vpc_pkg::OUT_W-1:0]       value_d;

	assign en       = !valid_q || out_ready;
	assign in_ready = en;

	// Negative values get the fraction mask added first so the shift rounds toward zero.
	always_comb begin
		if (in_item.acc[vpc_pkg::ACC_W-1]) begin
			bias = {{(SUM_W-COEF_FRAC_BITS){1'b0}}, {COEF_FRAC_BITS{1'b1}}};
		end else begin
			bias = '0;
		end
		biased = {in_item.acc[vpc_pkg::ACC_W-1], in_item.acc} + bias;
		quot   = biased >>> COEF_FRAC_BITS;
		ovf    = !((&quot[SUM_W-1:vpc_pkg::OUT_W-1]) || !(|quot[SUM_W-1:vpc_pkg::OUT_W-1]));
		if (ovf) begin
			value_d = quot[SUM_W-1] ? vpc_pkg::OUT_MIN : vpc_pkg::OUT_MAX;
		end else begin
			value_d = quot[vpc_pkg::OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			value_q <= value_d;
			sat_q   <= in_item.sat || ovf;
		end
	end

	assign out_valid = valid_q;
	assign out_value = value_q;
	assign out_sat   = sat_q;

endmodule

// ----- rtl/voxel_polynomial_calibration.sv -----
// Top level of the voxel polynomial calibration pipeline.
//
// Usage: voxel values arrive on the slave stream, one signed 16-bit value per
// transfer in s_axis_tdata. Each one yields exactly one result on the master
// stream: the calibrated value, truncated toward zero and clamped to signed
// 32 bits, in m_axis_tdata, and a saturation flag in m_axis_tuser that is set
// when any accumulator step or the final clamp clipped.
// The polynomial is evaluated by Horner's rule in a fixed chain of MAX_DEGREE
// steps, each a multiply stage and a saturating add stage; steps above the
// configured degree pass the accumulator through. With an entry register and
// an output register the item passes 2*MAX_DEGREE + 2 registers (14 with the
// default MAX_DEGREE of six); the pipeline takes one transfer in every cycle
// while m_axis_tready does not hold it back.
// Each stage carries its own valid bit and advances whenever the stage after
// it is empty or moving, so a stall on m_axis_tready only holds back the
// items that are queued behind it and empty stages still fill up. Nothing is
// dropped or repeated while stalled.
// Reset clears all valid bits and loads the register defaults: degree one,
// the linear coefficient 1.0 and all others zero. Registers should only be
// written while no transfers are in flight.
module voxel_polynomial_calibration #(
	parameter int MAX_DEGREE     = vpc_pkg::DEF_MAX_DEGREE,
	parameter int COEF_FRAC_BITS = vpc_pkg::DEF_COEF_FRAC_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Configuration write port.
	input  logic                               cfg_we,
	input  logic [vpc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [vpc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	// Input stream.
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [15:0]                        s_axis_tdata,  // [15:0] voxel_value
	// Output stream.
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [31:0]                        m_axis_tdata,  // [31:0] calibrated_value
	output logic                               m_axis_tuser   // [0] saturated
);

	localparam logic [vpc_pkg::DEG_W-1:0] MAX_DEG = vpc_pkg::DEG_W'(MAX_DEGREE);

	logic [vpc_pkg::DEG_W-1:0]              degree_q;
	logic signed [vpc_pkg::COEF_W-1:0]      coef_q [0:vpc_pkg::NUM_COEFS-1];
	logic [vpc_pkg::DEG_W-1:0]              deg_eff;

	logic                                   v_s1;
	vpc_pkg::vpc_item_t                     item_s1;
	logic                                   en_s1;

	logic                                   chain_valid [0:MAX_DEGREE];
	logic                                   chain_ready [0:MAX_DEGREE];
	vpc_pkg::vpc_item_t                     chain_item  [0:MAX_DEGREE];

	logic signed [vpc_pkg::OUT_W-1:0]       out_value;

	// Configuration registers. A degree above the chain length is clamped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= vpc_pkg::DEGREE_RESET;
			for (int i = 0; i < vpc_pkg::NUM_COEFS; i++) begin
				coef_q[i] <= '0;
			end
			coef_q[1] <= vpc_pkg::COEF_P1_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				vpc_pkg::CFG_DEGREE: begin
					degree_q <= cfg_wdata[vpc_pkg::DEG_W-1:0];
				end
				default: begin
					coef_q[vpc_pkg::CFG_IDX_W'(cfg_index - vpc_pkg::CFG_COEF_BASE)] <= cfg_wdata;
				end
			endcase
		end
	end

	assign deg_eff = (degree_q > MAX_DEG) ? MAX_DEG : degree_q;

	// Entry stage: capture the voxel and seed the accumulator with the leading coefficient.
	assign en_s1         = !v_s1 || chain_ready[0];
	assign s_axis_tready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && s_axis_tvalid) begin
			item_s1.x   <= s_axis_tdata;
			item_s1.acc <= vpc_pkg::ACC_W'(coef_q[deg_eff]);
			item_s1.sat <= 1'b0;
		end
	end

	assign chain_valid[0] = v_s1;
	assign chain_item[0]  = item_s1;

	// Step i folds in coefficient MAX_DEGREE-1-i, provided that lies below the degree.
	for (genvar i = 0; i < MAX_DEGREE; i++) begin : g_step
		localparam int K = MAX_DEGREE - 1 - i;

		vpc_horner_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.active    (vpc_pkg::DEG_W'(K) < deg_eff),
			.coef      (coef_q[K]),
			.in_valid  (chain_valid[i]),
			.in_ready  (chain_ready[i]),
			.in_item   (chain_item[i]),
			.out_valid (chain_valid[i+1]),
			.out_ready (chain_ready[i+1]),
			.out_item  (chain_item[i+1])
		);
	end

	vpc_round_sat #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_round (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chain_valid[MAX_DEGREE]),
		.in_ready  (chain_ready[MAX_DEGREE]),
		.in_item   (chain_item[MAX_DEGREE]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_value (out_value),
		.out_sat   (m_axis_tuser)
	);

	assign m_axis_tdata = out_value;

endmodule

// ----- rtl/vpc_checker.sv -----
// Port-level checker for the voxel polynomial calibration block, with its bind.
module vpc_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               cfg_we,
	input logic [vpc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input logic [vpc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input logic                               s_axis_tvalid,
	input logic                               s_axis_tready,
	input logic [15:0]                        s_axis_tdata,
	input logic                               m_axis_tvalid,
	input logic                               m_axis_tready,
	input logic [31:0]                        m_axis_tdata,
	input logic                               m_axis_tuser
);

	// A stalled result stays put until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed or vanished");

	// The input side only backs off when every stage is full and the output is stalled.
	a_full_only: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input refused while the pipeline had room");

	// Leaving reset, no result is on offer.
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_axis_tvalid)
		else $error("result valid straight after reset");

	// An offered voxel that is refused is held unchanged until it is taken.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
		else $error("refused input changed or vanished");

	// Handshake signals are always defined, and so is the payload of a transfer or write.
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({s_axis_tready, m_axis_tvalid}) &&
		(!m_axis_tvalid || !$isunknown({m_axis_tdata, m_axis_tuser})) &&
		(!cfg_we || !$isunknown({cfg_index, cfg_wdata})))
		else $error("undefined value on a port");

endmodule

bind voxel_polynomial_calibration vpc_checker u_vpc_checker (.*);
